@@ src/miq_pkg.sv @@
// shared types and constants for the middle insertion queue
// no dependencies; imported by miq_ctrl, miq_dpath and middle_insert_queue
package miq_pkg;

    localparam int OPCODE_W = 2;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 11;

    typedef logic [OPCODE_W-1:0] t_opcode;
    typedef logic [STATUS_W-1:0] t_status;

    // operation codes
    localparam t_opcode OP_PUSH_BACK = 2'd0;
    localparam t_opcode OP_PUSH_MID  = 2'd1;
    localparam t_opcode OP_POP_FRONT = 2'd2;

    // result status codes
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_EMPTY = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // flags from the datapath, taken from the registered counts
    typedef struct packed {
        logic empty;
        logic full;
        logic f_eq_b;
        logic b_zero;
    } t_dp_flags;

    // commands from the controller to the datapath
    typedef struct packed {
        logic    load;
        logic    front_push;
        logic    front_src_back;
        logic    front_pop;
        logic    back_push_tail;
        logic    back_push_head;
        logic    back_pop;
        logic    emit;
        logic    has_value;
        t_status status;
    } t_dp_cmd;

endpackage

@@ src/miq_ctrl.sv @@
// controller for the middle insertion queue: accepts a word and decides the moves
// depends on miq_pkg
module miq_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  miq_pkg::t_opcode    i_opcode,
    input  miq_pkg::t_dp_flags  i_flags,
    output miq_pkg::t_dp_cmd    o_cmd
);
    import miq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state  r_state, n_state;
    t_opcode r_op;
    logic    accept;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // state sequencing
    always_comb begin
        case (r_state)
            S_IDLE:  n_state = accept ? S_EXEC : S_IDLE;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_PUSH_BACK;
        end else begin
            r_state <= n_state;
            if (accept) begin
                r_op <= i_opcode;
            end
        end
    end

    // decide the memory moves for the latched operation
    always_comb begin
        o_cmd      = '0;
        o_cmd.load = accept;
        o_cmd.status = ST_OK;
        if (r_state == S_EXEC) begin
            o_cmd.emit = 1'b1;
            case (r_op)
                OP_PUSH_BACK: begin
                    if (i_flags.full) begin
                        o_cmd.status = ST_FULL;
                    end else if (i_flags.f_eq_b && i_flags.b_zero) begin
                        o_cmd.front_push = 1'b1;
                    end else if (i_flags.f_eq_b) begin
                        // back head moves over to the front, new word joins the back
                        o_cmd.front_push     = 1'b1;
                        o_cmd.front_src_back = 1'b1;
                        o_cmd.back_pop       = 1'b1;
                        o_cmd.back_push_tail = 1'b1;
                    end else begin
                        o_cmd.back_push_tail = 1'b1;
                    end
                end
                OP_PUSH_MID: begin
                    if (i_flags.full) begin
                        o_cmd.status = ST_FULL;
                    end else if (i_flags.f_eq_b) begin
                        o_cmd.front_push = 1'b1;
                    end else begin
                        o_cmd.back_push_head = 1'b1;
                    end
                end
                OP_POP_FRONT: begin
                    if (i_flags.empty) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.front_pop = 1'b1;
                        o_cmd.has_value = 1'b1;
                        // halves level before the pop: back half would end up longer
                        if (i_flags.f_eq_b) begin
                            o_cmd.front_push     = 1'b1;
                            o_cmd.front_src_back = 1'b1;
                            o_cmd.back_pop       = 1'b1;
                        end
                    end
                end
                default: begin
                    o_cmd.status = ST_OK;
                end
            endcase
        end
    end

endmodule

@@ src/miq_dpath.sv @@
// datapath for the middle insertion queue: the two half stores, pointers and result
// depends on miq_pkg
module miq_dpath #(
    parameter int CAPACITY = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  miq_pkg::t_dp_cmd            i_cmd,
    input  logic [miq_pkg::DATA_W-1:0]  i_value,
    output miq_pkg::t_dp_flags          o_flags,
    output logic                        o_valid,
    output logic [miq_pkg::DATA_W-1:0]  o_value_out,
    output logic                        o_has_value,
    output miq_pkg::t_status            o_status,
    output logic [miq_pkg::OCC_W-1:0]   o_occupancy
);
    import miq_pkg::*;

    localparam int DEPTH = (CAPACITY + 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NW    = CW + 1;

    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [NW-1:0] DEPTH_N  = NW'(DEPTH);
    localparam logic [NW-1:0] CAP_N    = NW'(CAPACITY);

    // half stores
    logic [DATA_W-1:0] front_mem [DEPTH];
    logic [DATA_W-1:0] back_mem  [DEPTH];

    logic [AW-1:0]     r_front_head, n_front_head;
    logic [CW-1:0]     r_front_count, n_front_count;
    logic [AW-1:0]     r_back_head, n_back_head;
    logic [CW-1:0]     r_back_count, n_back_count;
    logic [DATA_W-1:0] r_value;
    logic [DATA_W-1:0] r_front_rd, r_back_rd;
    logic [NW-1:0]     total;
    logic [NW-1:0]     n_total;
    logic [AW-1:0]     front_tail, back_tail, back_head_dec;
    logic [DATA_W-1:0] front_wdata;

    logic              r_valid;
    logic [DATA_W-1:0] r_value_out;
    logic              r_has_value;
    t_status           r_status;
    logic [OCC_W-1:0]  r_occupancy;

    // index of head plus count, wrapped once
    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] head,
                                               input logic [CW-1:0] count);
        logic [NW-1:0] sum;
        sum = NW'(head) + NW'(count);
        if (sum >= DEPTH_N) begin
            sum = sum - DEPTH_N;
        end
        return sum[AW-1:0];
    endfunction

    // status flags from the counts
    assign total          = NW'(r_front_count) + NW'(r_back_count);
    assign o_flags.empty  = (total == '0);
    assign o_flags.full   = (total >= CAP_N);
    assign o_flags.f_eq_b = (r_front_count == r_back_count);
    assign o_flags.b_zero = (r_back_count == '0);

    // write addresses and data
    assign front_tail    = wrap_add(r_front_head, r_front_count);
    assign back_tail     = wrap_add(r_back_head, r_back_count);
    assign back_head_dec = (r_back_head == '0) ? LAST_IDX : r_back_head - AW'(1);
    assign front_wdata   = i_cmd.front_src_back ? r_back_rd : r_value;

    // next pointers and counts
    always_comb begin
        n_front_head  = r_front_head;
        n_front_count = r_front_count;
        n_back_head   = r_back_head;
        n_back_count  = r_back_count;
        if (i_cmd.front_pop) begin
            n_front_head = (r_front_head == LAST_IDX) ? '0 : r_front_head + AW'(1);
        end
        if (i_cmd.front_push && !i_cmd.front_pop) begin
            n_front_count = r_front_count + CW'(1);
        end else if (i_cmd.front_pop && !i_cmd.front_push) begin
            n_front_count = r_front_count - CW'(1);
        end
        if (i_cmd.back_pop) begin
            n_back_head = (r_back_head == LAST_IDX) ? '0 : r_back_head + AW'(1);
        end else if (i_cmd.back_push_head) begin
            n_back_head = back_head_dec;
        end
        if ((i_cmd.back_push_tail || i_cmd.back_push_head) && !i_cmd.back_pop) begin
            n_back_count = r_back_count + CW'(1);
        end else if (i_cmd.back_pop && !i_cmd.back_push_tail) begin
            n_back_count = r_back_count - CW'(1);
        end
        n_total = NW'(n_front_count) + NW'(n_back_count);
    end

    // front store: head read every cycle, tail write on push
    always_ff @(posedge i_clk) begin
        r_front_rd <= front_mem[r_front_head];
        if (i_cmd.front_push) begin
            front_mem[front_tail] <= front_wdata;
        end
    end

    // back store: head read every cycle, write at tail or below the head
    always_ff @(posedge i_clk) begin
        r_back_rd <= back_mem[r_back_head];
        if (i_cmd.back_push_tail) begin
            back_mem[back_tail] <= r_value;
        end else if (i_cmd.back_push_head) begin
            back_mem[back_head_dec] <= r_value;
        end
    end

    // incoming word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_value <= i_value;
        end
    end

    // pointers, counts and result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_head  <= '0;
            r_front_count <= '0;
            r_back_head   <= '0;
            r_back_count  <= '0;
            r_valid       <= 1'b0;
        end else begin
            r_front_head  <= n_front_head;
            r_front_count <= n_front_count;
            r_back_head   <= n_back_head;
            r_back_count  <= n_back_count;
            r_valid       <= i_cmd.emit;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_value_out <= i_cmd.has_value ? r_front_rd : '0;
            r_has_value <= i_cmd.has_value;
            r_status    <= i_cmd.status;
            r_occupancy <= OCC_W'(n_total);
        end
    end

    assign o_valid     = r_valid;
    assign o_value_out = r_value_out;
    assign o_has_value = r_has_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occupancy;

endmodule

@@ src/middle_insert_queue.sv @@
// top level of the middle insertion queue: controller, datapath and checks
// depends on miq_pkg, miq_ctrl and miq_dpath

// A bounded queue of signed 32-bit words with push back, insert at the middle
// (index ceil(n/2)) and pop front. A word is taken when start is high and busy
// is low. In every operation the accepting edge also registers the reads of
// both half-store heads, and the execute state does the writes,
// the pointer moves and the rebalance. The result appears on the o_ ports for
// exactly one cycle with o_valid, in the cycle busy drops, and a new start can
// be taken in that same cycle, but none while busy is high. The receiver
// cannot stall. Every operation gives one result; occupancy is reported after
// the operation. Store contents are not cleared at reset and need no clearing.
module middle_insert_queue #(
    parameter int CAPACITY = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic        [miq_pkg::OPCODE_W-1:0] i_opcode,
    input  logic signed [miq_pkg::DATA_W-1:0]   i_value,
    output logic                                o_valid,
    output logic signed [miq_pkg::DATA_W-1:0]   o_value_out,
    output logic                                o_has_value,
    output logic        [miq_pkg::STATUS_W-1:0] o_status,
    output logic        [miq_pkg::OCC_W-1:0]    o_occupancy
);
    import miq_pkg::*;

    t_dp_flags         flags;
    t_dp_cmd           cmd;
    logic [DATA_W-1:0] value_out;

    // controller
    miq_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_opcode (i_opcode),
        .i_flags  (flags),
        .o_cmd    (cmd)
    );

    // datapath
    miq_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_value     (i_value),
        .o_flags     (flags),
        .o_valid     (o_valid),
        .o_value_out (value_out),
        .o_has_value (o_has_value),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    assign o_value_out = value_out;

    // an accepted word makes the block busy in the next cycle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    // every accepted word gives its result strobe once the execute state has passed
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing after accept");

    // busy only drops together with a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_valid)
        else $error("busy dropped without a result");

    // a popped word only comes with an ok status
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_has_value) |-> (o_status == ST_OK))
        else $error("popped word with an error status");

endmodule
